// ===== sv/rdq_pkg.sv =====
// Shared constants, codes and types for the restricted deque.
package rdq_pkg;

  localparam int DEPTH   = 64;
  localparam int WORD_W  = 32;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_REAR   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_DENIED = 2'd3
  } status_t;

  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_IN_RESTR = 2'd1;
  localparam logic [1:0] MODE_OUT_RESTR = 2'd2;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

endpackage

// ===== sv/rdq_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module rdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/restricted_deque.sv =====
// Restricted double-ended queue of 64 signed 32-bit words, ring-buffer storage.
//
// Input channel (in_valid / in_stall, op, value) carries one operation per word:
// push rear, push front, pop rear or pop front. Output channel (out_valid /
// out_stall, data, status, fill_count) returns one result word per operation.
// cfg_wr_en / cfg_wr_data write the restriction mode; write only while idle.
//
// Timing: a push, or any refused operation, shows its result in the cycle after
// acceptance. A successful pop reads the word RAM (registered read port), then
// S_READ registers the popped word into the output register.
// Throughput: one push per cycle while the receiver does not stall; a pop holds
// off the next operation in S_READ until its RAM read is complete.
//
// A finished result sits in the output register; the next word is taken as
// soon as that register is free or being drained in the same cycle. While the
// receiver stalls, in_stall stays high and the result holds.
// Reset (rst, synchronous) empties the queue, clears the mode to unrestricted
// and drops out_valid. RAM contents are not cleared; no stale entry is read.
module restricted_deque (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] data,
  output logic [1:0]         status,
  output logic [6:0]         fill_count
);

  localparam int PW = rdq_pkg::PTR_W;
  localparam int CW = rdq_pkg::COUNT_W;

  rdq_pkg::state_t state, state_next;
  logic [1:0]      mode;
  logic [PW-1:0]   head, head_next;
  logic [PW-1:0]   tail, tail_next;
  logic [CW-1:0]   occupancy, occupancy_next;
  logic            out_valid_next;
  logic [31:0]     data_next;
  logic [1:0]      status_next;
  logic [CW-1:0]   fill_count_next;

  logic            ram_we, ram_re;
  logic [PW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_rdata;

  logic            accept, denied, full, empty;
  logic [PW-1:0]   head_prev, head_succ, tail_prev, tail_succ;
  rdq_pkg::op_t    op_code;

  rdq_ram #(
    .WIDTH (rdq_pkg::WORD_W),
    .DEPTH (rdq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != rdq_pkg::S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign op_code  = rdq_pkg::op_t'(op);

  assign denied = ((op_code == rdq_pkg::OP_PUSH_REAR) && (mode == rdq_pkg::MODE_IN_RESTR)) ||
                  ((op_code == rdq_pkg::OP_POP_FRONT) && (mode == rdq_pkg::MODE_OUT_RESTR));
  assign full   = (occupancy == CW'(rdq_pkg::DEPTH));
  assign empty  = (occupancy == '0);

  assign head_prev = (head == '0) ? PW'(rdq_pkg::DEPTH - 1) : head - PW'(1);
  assign head_succ = (head == PW'(rdq_pkg::DEPTH - 1)) ? '0 : head + PW'(1);
  assign tail_prev = (tail == '0) ? PW'(rdq_pkg::DEPTH - 1) : tail - PW'(1);
  assign tail_succ = (tail == PW'(rdq_pkg::DEPTH - 1)) ? '0 : tail + PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rdq_pkg::S_IDLE;
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      occupancy <= occupancy_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= rdq_pkg::MODE_NONE;
    end else if (cfg_wr_en) begin
      mode <= cfg_wr_data;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    data       <= data_next;
    status     <= status_next;
    fill_count <= fill_count_next;
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    occupancy_next  = occupancy;
    out_valid_next  = out_valid && out_stall;
    data_next       = data;
    status_next     = status;
    fill_count_next = fill_count;
    ram_we          = 1'b0;
    ram_waddr       = tail;
    ram_re          = 1'b0;
    ram_raddr       = head;

    case (state)
      rdq_pkg::S_IDLE: begin
        if (accept) begin
          out_valid_next  = 1'b1;
          data_next       = '0;
          status_next     = rdq_pkg::ST_OK;
          fill_count_next = occupancy;
          if (denied) begin
            status_next = rdq_pkg::ST_DENIED;
          end else begin
            case (op_code)
              rdq_pkg::OP_PUSH_REAR: begin
                if (full) begin
                  status_next = rdq_pkg::ST_FULL;
                end else begin
                  ram_we          = 1'b1;
                  ram_waddr       = tail;
                  tail_next       = tail_succ;
                  occupancy_next  = occupancy + CW'(1);
                  fill_count_next = occupancy + CW'(1);
                end
              end
              rdq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                  status_next = rdq_pkg::ST_FULL;
                end else begin
                  ram_we          = 1'b1;
                  ram_waddr       = head_prev;
                  head_next       = head_prev;
                  occupancy_next  = occupancy + CW'(1);
                  fill_count_next = occupancy + CW'(1);
                end
              end
              rdq_pkg::OP_POP_REAR: begin
                if (empty) begin
                  status_next = rdq_pkg::ST_EMPTY;
                end else begin
                  ram_re          = 1'b1;
                  ram_raddr       = tail_prev;
                  tail_next       = tail_prev;
                  occupancy_next  = occupancy - CW'(1);
                  fill_count_next = occupancy - CW'(1);
                  out_valid_next  = 1'b0;
                  state_next      = rdq_pkg::S_READ;
                end
              end
              rdq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                  status_next = rdq_pkg::ST_EMPTY;
                end else begin
                  ram_re          = 1'b1;
                  ram_raddr       = head;
                  head_next       = head_succ;
                  occupancy_next  = occupancy - CW'(1);
                  fill_count_next = occupancy - CW'(1);
                  out_valid_next  = 1'b0;
                  state_next      = rdq_pkg::S_READ;
                end
              end
              default: begin
                status_next = rdq_pkg::ST_DENIED;
              end
            endcase
          end
        end
      end
      rdq_pkg::S_READ: begin
        // popped word arrives from the RAM this cycle
        data_next      = ram_rdata;
        out_valid_next = 1'b1;
        state_next     = rdq_pkg::S_IDLE;
      end
      default: begin
        state_next = rdq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the restricted deque: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, acts as unrestricted
  localparam int ROWS = 28;
  localparam int PHASES = 10;
  localparam int PHASE_WORDS = 95;

  typedef struct packed {
    logic signed [rdq_pkg::WORD_W-1:0] data;
    rdq_pkg::status_t                  status;
    logic [rdq_pkg::COUNT_W-1:0]       fill;
  } deque_result_t;

  typedef enum logic [0:0] {ROW_OP = 1'b0, ROW_MODE = 1'b1} row_kind_t;

  typedef struct packed {
    row_kind_t                         kind;
    rdq_pkg::op_t                      opcode;
    logic signed [rdq_pkg::WORD_W-1:0] word;
    int                                rep;
    bit                                pinned;
    deque_result_t                     known;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_wr_data = rdq_pkg::MODE_NONE;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         op = rdq_pkg::OP_PUSH_REAR;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] data;
  logic [1:0]         status;
  logic [6:0]         fill_count;

  restricted_deque dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data       (data),
    .status     (status),
    .fill_count (fill_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Directed table; the fill-to-capacity row uses incrementing words.
  stim_row_t plan [0:ROWS-1] = '{
    '{ROW_OP, rdq_pkg::OP_POP_REAR, 32'sd0, 1, 1'b1, '{32'sd0, rdq_pkg::ST_EMPTY, 7'd0}},
    '{ROW_OP, rdq_pkg::OP_POP_FRONT, 32'sd0, 1, 1'b1, '{32'sd0, rdq_pkg::ST_EMPTY, 7'd0}},
    '{ROW_OP, rdq_pkg::OP_PUSH_REAR, 32'sh7fffffff, 1, 1'b1, '{32'sd0, rdq_pkg::ST_OK, 7'd1}},
    '{ROW_OP, rdq_pkg::OP_PUSH_FRONT, 32'sh80000000, 1, 1'b1, '{32'sd0, rdq_pkg::ST_OK, 7'd2}},
    '{ROW_OP, rdq_pkg::OP_POP_FRONT, 32'sd0, 1, 1'b1,
      '{32'sh80000000, rdq_pkg::ST_OK, 7'd1}},
    '{ROW_OP, rdq_pkg::OP_POP_REAR, 32'sd0, 1, 1'b1,
      '{32'sh7fffffff, rdq_pkg::ST_OK, 7'd0}},
    '{ROW_OP, rdq_pkg::OP_PUSH_REAR, -32'sd1, 1, 1'b0, '0},
    '{ROW_OP, rdq_pkg::OP_PUSH_FRONT, 32'sd0, 1, 1'b0, '0},
    '{ROW_OP, rdq_pkg::OP_POP_REAR, 32'sd0, 1, 1'b0, '0},
    '{ROW_OP, rdq_pkg::OP_PUSH_FRONT, 32'sh55555555, 63, 1'b0, '0},
    '{ROW_OP, rdq_pkg::OP_PUSH_REAR, 32'sd1, 1, 1'b1, '{32'sd0, rdq_pkg::ST_FULL, 7'd64}},
    '{ROW_OP, rdq_pkg::OP_PUSH_FRONT, 32'sd2, 1, 1'b1, '{32'sd0, rdq_pkg::ST_FULL, 7'd64}},
    '{ROW_OP, rdq_pkg::OP_POP_REAR, 32'sd0, 64, 1'b0, '0},
    '{ROW_OP, rdq_pkg::OP_POP_FRONT, 32'sd0, 1, 1'b1, '{32'sd0, rdq_pkg::ST_EMPTY, 7'd0}},
    '{ROW_MODE, rdq_pkg::OP_PUSH_REAR, 32'(rdq_pkg::MODE_IN_RESTR), 1, 1'b0, '0},
    '{ROW_OP, rdq_pkg::OP_PUSH_REAR, 32'sd3, 1, 1'b1, '{32'sd0, rdq_pkg::ST_DENIED, 7'd0}},
    '{ROW_OP, rdq_pkg::OP_PUSH_FRONT, 32'shaaaaaaaa, 1, 1'b1, '{32'sd0, rdq_pkg::ST_OK, 7'd1}},
    '{ROW_OP, rdq_pkg::OP_POP_REAR, 32'sd0, 1, 1'b0, '0},
    '{ROW_MODE, rdq_pkg::OP_PUSH_REAR, 32'(rdq_pkg::MODE_OUT_RESTR), 1, 1'b0, '0},
    '{ROW_OP, rdq_pkg::OP_POP_FRONT, 32'sd0, 1, 1'b1, '{32'sd0, rdq_pkg::ST_DENIED, 7'd0}},
    '{ROW_OP, rdq_pkg::OP_PUSH_REAR, 32'sh0f0f0f0f, 1, 1'b1, '{32'sd0, rdq_pkg::ST_OK, 7'd1}},
    '{ROW_OP, rdq_pkg::OP_PUSH_FRONT, 32'shf0f0f0f0, 1, 1'b0, '0},
    '{ROW_OP, rdq_pkg::OP_POP_FRONT, 32'sd0, 1, 1'b1, '{32'sd0, rdq_pkg::ST_DENIED, 7'd2}},
    '{ROW_OP, rdq_pkg::OP_POP_REAR, 32'sd0, 2, 1'b0, '0},
    '{ROW_MODE, rdq_pkg::OP_PUSH_REAR, 32'(MODE_SPARE), 1, 1'b0, '0},
    '{ROW_OP, rdq_pkg::OP_PUSH_REAR, 32'sh12345678, 1, 1'b1, '{32'sd0, rdq_pkg::ST_OK, 7'd1}},
    '{ROW_OP, rdq_pkg::OP_POP_FRONT, 32'sd0, 1, 1'b0, '0},
    '{ROW_MODE, rdq_pkg::OP_PUSH_REAR, 32'(rdq_pkg::MODE_NONE), 1, 1'b0, '0}
  };

  // Own copy of the deque state
  logic signed [rdq_pkg::WORD_W-1:0] ring [rdq_pkg::DEPTH];
  logic [rdq_pkg::PTR_W-1:0]         front_ptr, back_ptr;
  int                                held;
  logic [1:0]                        mode;

  deque_result_t pending_results [$];
  deque_result_t pin_res;
  bit            pin_en = 1'b0;
  bit            quiet = 1'b0;
  int            errors = 0;
  int            words_taken = 0;
  int            results_seen = 0;
  int            status_tally [4] = '{0, 0, 0, 0};
  int            stall_left = 0;

  function automatic deque_result_t apply_op(rdq_pkg::op_t o,
                                             logic signed [rdq_pkg::WORD_W-1:0] w);
    deque_result_t r;
    r = '{data: '0, status: rdq_pkg::ST_OK, fill: '0};
    if ((o == rdq_pkg::OP_PUSH_REAR && mode == rdq_pkg::MODE_IN_RESTR) ||
        (o == rdq_pkg::OP_POP_FRONT && mode == rdq_pkg::MODE_OUT_RESTR)) begin
      r.status = rdq_pkg::ST_DENIED;
    end else if (o == rdq_pkg::OP_PUSH_REAR || o == rdq_pkg::OP_PUSH_FRONT) begin
      if (held >= rdq_pkg::DEPTH) begin
        r.status = rdq_pkg::ST_FULL;
      end else if (o == rdq_pkg::OP_PUSH_REAR) begin
        ring[back_ptr] = w;
        back_ptr = rdq_pkg::PTR_W'((back_ptr + 1) % rdq_pkg::DEPTH);
        held++;
      end else begin
        front_ptr = rdq_pkg::PTR_W'((front_ptr + rdq_pkg::DEPTH - 1) % rdq_pkg::DEPTH);
        ring[front_ptr] = w;
        held++;
      end
    end else begin
      if (held == 0) begin
        r.status = rdq_pkg::ST_EMPTY;
      end else if (o == rdq_pkg::OP_POP_REAR) begin
        back_ptr = rdq_pkg::PTR_W'((back_ptr + rdq_pkg::DEPTH - 1) % rdq_pkg::DEPTH);
        r.data = ring[back_ptr];
        held--;
      end else begin
        r.data = ring[front_ptr];
        front_ptr = rdq_pkg::PTR_W'((front_ptr + 1) % rdq_pkg::DEPTH);
        held--;
      end
    end
    r.fill = rdq_pkg::COUNT_W'(held);
    return r;
  endfunction

  task automatic note_field(string fname, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  // Sample at the rising edge: check results, then predict the word just taken
  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      front_ptr = '0;
      back_ptr = '0;
      held = 0;
      mode = rdq_pkg::MODE_NONE;
      pending_results.delete();
    end else begin
      if (cfg_wr_en)
        mode = cfg_wr_data;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t ns: result with nothing expected, got data %0d status %0d fill %0d",
                   $time, data, status, fill_count);
          errors++;
        end else begin
          want = pending_results.pop_front();
          note_field("data", want.data, data);
          note_field("status", want.status, status);
          note_field("fill_count", want.fill, fill_count);
        end
        if (!$isunknown(status))
          status_tally[status]++;
      end
      if (in_valid && !in_stall) begin
        want = apply_op(rdq_pkg::op_t'(op), value);
        if (pin_en)
          want = pin_res;
        pending_results.push_back(want);
        words_taken++;
      end
    end
  end

  function automatic int idle_gap();
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(99);
    if (r < 60)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver stall pattern, changed at the falling edge
  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(99) < 35) begin
      out_stall <= 1'b1;
      stall_left = idle_gap();
    end else begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_word(rdq_pkg::op_t o, logic signed [31:0] w, int gap, bit pinned,
                            deque_result_t known);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    value <= w;
    pin_en <= pinned;
    pin_res <= known;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'sd0;
      1: return -32'sd1;
      2: return 32'sh80000000;
      3: return 32'sh7fffffff;
      default: return $urandom;
    endcase
  endfunction

  int phase_mode [PHASES] = '{0, 1, 2, 3, 0, 2, 1, 0, 2, 0};
  int push_bias  [PHASES] = '{80, 30, 85, 20, 60, 75, 40, 50, 90, 10};

  initial begin
    int           waited;
    rdq_pkg::op_t pick;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_MODE) begin
        set_mode(plan[r].word[1:0]);
      end else begin
        for (int i = 0; i < plan[r].rep; i++)
          drive_word(plan[r].opcode, plan[r].word + i, idle_gap(), plan[r].pinned,
                     plan[r].known);
      end
    end

    // Random phases: each picks a mode and a push/pop balance to sweep full and empty
    for (int p = 0; p < PHASES; p++) begin
      set_mode(phase_mode[p][1:0]);
      quiet = (p == 4 || p == 8);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(99) < push_bias[p])
          pick = $urandom_range(1) ? rdq_pkg::OP_PUSH_FRONT : rdq_pkg::OP_PUSH_REAR;
        else
          pick = $urandom_range(1) ? rdq_pkg::OP_POP_FRONT : rdq_pkg::OP_POP_REAR;
        drive_word(pick, rand_word(), idle_gap(), 1'b0, '0);
      end
      quiet = 1'b0;
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, pending_results.size());
      errors++;
    end

    $display("Run: %0d words sent, %0d results checked, all four modes visited.",
             words_taken, results_seen);
    $display("Status mix: ok %0d, full %0d, empty %0d, refused by mode %0d.",
             status_tally[rdq_pkg::ST_OK], status_tally[rdq_pkg::ST_FULL],
             status_tally[rdq_pkg::ST_EMPTY], status_tally[rdq_pkg::ST_DENIED]);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t ns: timed out", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
